// ===== src/tmc_pkg.sv =====
package tmc_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 8;

  // result field widths
  localparam int SIDE_W  = 25;
  localparam int PERIM_W = 27;
  localparam int AREA_W  = 32;
  localparam int CIRC_W  = 32;

  // internal widths
  localparam int DIFF_W   = COORD_BITS + 1;
  localparam int SQ_W     = 2 * DIFF_W;
  localparam int CROSS_W  = 2 * DIFF_W + 1;
  localparam int RADI_W   = 2 * SIDE_W;
  localparam int SREM_W   = SIDE_W + 3;
  localparam int NUMI_W   = AREA_W + 2 * FRAC_BITS;
  localparam int ICMP_W   = PERIM_W + SIDE_W;
  localparam int PROD2_W  = 2 * SIDE_W;
  localparam int NUMC_W   = 3 * SIDE_W;
  localparam int DIV_W    = AREA_W + 2 * FRAC_BITS + 1;
  localparam int CCMP_W   = DIV_W + CIRC_W;

  // stage numbers: register k holds the result of stage k
  localparam int ST_DIFF  = 1;
  localparam int ST_MUL   = 2;
  localparam int ST_SUM   = 3;
  localparam int ST_SQ0   = 4;
  localparam int ST_SQN   = ST_SQ0 + SIDE_W - 1;
  localparam int ST_PER   = ST_SQN + 1;
  localparam int ST_IINIT = ST_PER + 1;
  localparam int ST_PMUL  = ST_PER + 1;
  localparam int ST_PSUM  = ST_PER + 2;
  localparam int ST_CINIT = ST_PER + 3;
  localparam int ST_ID0   = ST_IINIT + 1;
  localparam int ST_IDN   = ST_ID0 + SIDE_W - 1;
  localparam int ST_CD0   = ST_CINIT + 1;
  localparam int ST_CDN   = ST_CD0 + CIRC_W - 1;
  localparam int NST      = ST_CDN + 1;

  localparam logic [1:0] CLS_EQUI  = 2'd0;
  localparam logic [1:0] CLS_ISOS  = 2'd1;
  localparam logic [1:0] CLS_RIGHT = 2'd2;
  localparam logic [1:0] CLS_OTHER = 2'd3;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [CROSS_W-1:0]    cross_t;
  typedef logic [SQ_W-1:0]              sq_t;
  typedef logic [RADI_W-1:0]            radi_t;
  typedef logic [SREM_W-1:0]            srem_t;
  typedef logic [NUMI_W-1:0]            numi_t;
  typedef logic [ICMP_W-1:0]            icmp_t;
  typedef logic [NUMC_W-1:0]            numc_t;
  typedef logic [DIV_W-1:0]             div_t;
  typedef logic [CCMP_W-1:0]            ccmp_t;
  typedef logic [PERIM_W-1:0]           perim_t;
  typedef logic [AREA_W-1:0]            area_t;

  typedef struct packed {
    coord_t                        ax;
    coord_t                        ay;
    coord_t                        bx;
    coord_t                        by_coord;
    coord_t                        cx;
    coord_t                        cy;
    logic [5:0][DIFF_W-1:0]        d;
    logic [5:0][SQ_W-1:0]          sqp;
    cross_t                        mc0;
    cross_t                        mc1;
    logic [2:0][SQ_W-1:0]          sq;
    logic [2:0][RADI_W-1:0]        rad;
    logic [2:0][SREM_W-1:0]        srem;
    logic [2:0][SIDE_W-1:0]        root;
    logic [AREA_W-1:0]             at;
    logic [PERIM_W-1:0]            per;
    logic [1:0]                    cls;
    logic                          degen;
    logic [PROD2_W-1:0]            prod2;
    logic [PROD2_W-1:0]            plo;
    logic [PROD2_W-1:0]            phi;
    logic [NUMC_W-1:0]             numc;
    logic [DIV_W-1:0]              div;
    logic                          isat;
    logic [PERIM_W:0]              irem;
    logic [SIDE_W-1:0]             iq;
    logic                          csat;
    logic [DIV_W:0]                crem;
    logic [CIRC_W-1:0]             cq;
    logic [SIDE_W-1:0]             inr_o;
    logic [CIRC_W-1:0]             circ_o;
    logic                          csat_o;
  } stage_t;

endpackage

// ===== src/tmc_vtx_if.sv =====
interface tmc_vtx_if;
  logic                   valid;
  logic                   ready;
  logic signed [tmc_pkg::COORD_BITS-1:0] ax;
  logic signed [tmc_pkg::COORD_BITS-1:0] ay;
  logic signed [tmc_pkg::COORD_BITS-1:0] bx;
  logic signed [tmc_pkg::COORD_BITS-1:0] by_coord;
  logic signed [tmc_pkg::COORD_BITS-1:0] cx;
  logic signed [tmc_pkg::COORD_BITS-1:0] cy;

  modport source(output valid, ax, ay, bx, by_coord, cx, cy, input ready);
  modport sink(input valid, ax, ay, bx, by_coord, cx, cy, output ready);
endinterface

// ===== src/tmc_met_if.sv =====
interface tmc_met_if;
  logic                         valid;
  logic                         ready;
  logic [tmc_pkg::SIDE_W-1:0]   side_ab;
  logic [tmc_pkg::SIDE_W-1:0]   side_bc;
  logic [tmc_pkg::SIDE_W-1:0]   side_ac;
  logic [tmc_pkg::PERIM_W-1:0]  perimeter;
  logic [tmc_pkg::AREA_W-1:0]   area_twice;
  logic [1:0]                   shape_class;
  logic [tmc_pkg::SIDE_W-1:0]   inradius;
  logic [tmc_pkg::CIRC_W-1:0]   circumradius;
  logic                         degenerate;
  logic                         circum_saturated;

  modport source(output valid, side_ab, side_bc, side_ac, perimeter, area_twice,
                 shape_class, inradius, circumradius, degenerate, circum_saturated,
                 input ready);
  modport sink(input valid, side_ab, side_bc, side_ac, perimeter, area_twice,
               shape_class, inradius, circumradius, degenerate, circum_saturated,
               output ready);
endinterface

// ===== src/triangle_metrics_and_class.sv =====
// Throughput: one word per cycle unless stalled; the 65 stages (difference,
// square, sum, 25 square root digits, perimeter, product, a restoring divider
// of one quotient bit per stage for each radius, output) advance together and
// hold as a whole on a stall.
// Reset clears the valid bits of all stages; the data registers are not reset.
module triangle_metrics_and_class (
  input logic       clk,
  input logic       rst,
  tmc_vtx_if.sink   vertices,
  tmc_met_if.source metrics
);

  tmc_pkg::stage_t            p [tmc_pkg::NST+1];
  logic [tmc_pkg::NST:0]      v;
  logic                       adv;

  assign adv            = !v[tmc_pkg::NST] || metrics.ready;
  assign vertices.ready = adv && !rst;
  assign v[0]           = vertices.valid;

  always_comb begin
    p[0]          = '0;
    p[0].ax       = vertices.ax;
    p[0].ay       = vertices.ay;
    p[0].bx       = vertices.bx;
    p[0].by_coord = vertices.by_coord;
    p[0].cx       = vertices.cx;
    p[0].cy       = vertices.cy;
  end

  for (genvar k = 1; k <= tmc_pkg::NST; k++) begin : g_st
    tmc_pkg::stage_t nx;

    always_comb begin
      tmc_pkg::diff_t      ds;
      logic [tmc_pkg::DIFF_W-1:0] ua;
      tmc_pkg::cross_t     cr;
      tmc_pkg::srem_t      r2;
      tmc_pkg::srem_t      trial;
      logic [tmc_pkg::SQ_W:0] s_ab, s_bc, s_ca;
      tmc_pkg::numi_t      num_i;
      logic [tmc_pkg::PERIM_W:0] ir2;
      logic [tmc_pkg::DIV_W:0]   cr2;
      nx = p[k-1];

      if (k == tmc_pkg::ST_DIFF) begin
        nx.d[0] = tmc_pkg::diff_t'(p[k-1].bx) - tmc_pkg::diff_t'(p[k-1].ax);
        nx.d[1] = tmc_pkg::diff_t'(p[k-1].by_coord) - tmc_pkg::diff_t'(p[k-1].ay);
        nx.d[2] = tmc_pkg::diff_t'(p[k-1].cx) - tmc_pkg::diff_t'(p[k-1].bx);
        nx.d[3] = tmc_pkg::diff_t'(p[k-1].cy) - tmc_pkg::diff_t'(p[k-1].by_coord);
        nx.d[4] = tmc_pkg::diff_t'(p[k-1].cx) - tmc_pkg::diff_t'(p[k-1].ax);
        nx.d[5] = tmc_pkg::diff_t'(p[k-1].cy) - tmc_pkg::diff_t'(p[k-1].ay);
      end

      if (k == tmc_pkg::ST_MUL) begin
        for (int i = 0; i < 6; i++) begin
          ds = $signed(p[k-1].d[i]);
          ua = (ds < 0) ? tmc_pkg::DIFF_W'(-ds) : tmc_pkg::DIFF_W'(ds);
          nx.sqp[i] = tmc_pkg::sq_t'(ua) * tmc_pkg::sq_t'(ua);
        end
        // cross product (B-A) x (C-A)
        nx.mc0 = tmc_pkg::cross_t'($signed(p[k-1].d[0])) *
                 tmc_pkg::cross_t'($signed(p[k-1].d[5]));
        nx.mc1 = tmc_pkg::cross_t'($signed(p[k-1].d[1])) *
                 tmc_pkg::cross_t'($signed(p[k-1].d[4]));
      end

      if (k == tmc_pkg::ST_SUM) begin
        for (int j = 0; j < 3; j++) begin
          nx.sq[j]   = p[k-1].sqp[2*j] + p[k-1].sqp[2*j+1];
          nx.rad[j]  = tmc_pkg::radi_t'(nx.sq[j]) << (2 * tmc_pkg::FRAC_BITS);
          nx.srem[j] = '0;
          nx.root[j] = '0;
        end
        cr    = p[k-1].mc0 - p[k-1].mc1;
        nx.at = (cr < 0) ? tmc_pkg::AREA_W'(-cr) : tmc_pkg::AREA_W'(cr);
      end

      // one root digit per stage for all three sides
      if (k >= tmc_pkg::ST_SQ0 && k <= tmc_pkg::ST_SQN) begin
        for (int j = 0; j < 3; j++) begin
          r2    = {p[k-1].srem[j][tmc_pkg::SREM_W-3:0],
                   p[k-1].rad[j][tmc_pkg::RADI_W-1 -: 2]};
          trial = tmc_pkg::srem_t'({p[k-1].root[j], 2'b01});
          if (r2 >= trial) begin
            nx.srem[j] = r2 - trial;
            nx.root[j] = {p[k-1].root[j][tmc_pkg::SIDE_W-2:0], 1'b1};
          end else begin
            nx.srem[j] = r2;
            nx.root[j] = {p[k-1].root[j][tmc_pkg::SIDE_W-2:0], 1'b0};
          end
          nx.rad[j] = p[k-1].rad[j] << 2;
        end
      end

      if (k == tmc_pkg::ST_PER) begin
        nx.per   = tmc_pkg::perim_t'(p[k-1].root[0]) + tmc_pkg::perim_t'(p[k-1].root[1])
                 + tmc_pkg::perim_t'(p[k-1].root[2]);
        nx.degen = (p[k-1].at == '0);
        nx.prod2 = tmc_pkg::PROD2_W'(p[k-1].root[0]) * tmc_pkg::PROD2_W'(p[k-1].root[1]);
        s_ab = {1'b0, p[k-1].sq[0]} + {1'b0, p[k-1].sq[1]};
        s_bc = {1'b0, p[k-1].sq[1]} + {1'b0, p[k-1].sq[2]};
        s_ca = {1'b0, p[k-1].sq[2]} + {1'b0, p[k-1].sq[0]};
        priority if (p[k-1].sq[0] == p[k-1].sq[1] && p[k-1].sq[1] == p[k-1].sq[2])
          nx.cls = tmc_pkg::CLS_EQUI;
        else if (p[k-1].sq[0] == p[k-1].sq[1] || p[k-1].sq[1] == p[k-1].sq[2] ||
                 p[k-1].sq[2] == p[k-1].sq[0])
          nx.cls = tmc_pkg::CLS_ISOS;
        else if (s_ab == {1'b0, p[k-1].sq[2]} || s_bc == {1'b0, p[k-1].sq[0]} ||
                 s_ca == {1'b0, p[k-1].sq[1]})
          nx.cls = tmc_pkg::CLS_RIGHT;
        else
          nx.cls = tmc_pkg::CLS_OTHER;
      end

      if (k == tmc_pkg::ST_IINIT) begin
        num_i   = tmc_pkg::numi_t'(p[k-1].at) << (2 * tmc_pkg::FRAC_BITS);
        nx.isat = tmc_pkg::icmp_t'(num_i) >=
                  (tmc_pkg::icmp_t'(p[k-1].per) << tmc_pkg::SIDE_W);
        nx.irem = (tmc_pkg::PERIM_W+1)'(num_i >> tmc_pkg::SIDE_W);
        nx.iq   = num_i[tmc_pkg::SIDE_W-1:0];
      end

      if (k == tmc_pkg::ST_PMUL) begin
        nx.plo = tmc_pkg::PROD2_W'(p[k-1].prod2[tmc_pkg::SIDE_W-1:0]) *
                 tmc_pkg::PROD2_W'(p[k-1].root[2]);
        nx.phi = tmc_pkg::PROD2_W'(p[k-1].prod2[tmc_pkg::PROD2_W-1:tmc_pkg::SIDE_W]) *
                 tmc_pkg::PROD2_W'(p[k-1].root[2]);
      end

      if (k == tmc_pkg::ST_PSUM) begin
        nx.numc = (tmc_pkg::numc_t'(p[k-1].phi) << tmc_pkg::SIDE_W) +
                  tmc_pkg::numc_t'(p[k-1].plo);
        nx.div  = tmc_pkg::div_t'(p[k-1].at) << (2 * tmc_pkg::FRAC_BITS + 1);
      end

      if (k == tmc_pkg::ST_CINIT) begin
        nx.csat = tmc_pkg::ccmp_t'(p[k-1].numc) >=
                  (tmc_pkg::ccmp_t'(p[k-1].div) << tmc_pkg::CIRC_W);
        nx.crem = (tmc_pkg::DIV_W+1)'(p[k-1].numc >> tmc_pkg::CIRC_W);
        nx.cq   = p[k-1].numc[tmc_pkg::CIRC_W-1:0];
      end

      // restoring division, one quotient bit per stage
      if (k >= tmc_pkg::ST_ID0 && k <= tmc_pkg::ST_IDN) begin
        ir2 = {p[k-1].irem[tmc_pkg::PERIM_W-1:0], p[k-1].iq[tmc_pkg::SIDE_W-1]};
        if (ir2 >= {1'b0, p[k-1].per}) begin
          nx.irem = ir2 - {1'b0, p[k-1].per};
          nx.iq   = {p[k-1].iq[tmc_pkg::SIDE_W-2:0], 1'b1};
        end else begin
          nx.irem = ir2;
          nx.iq   = {p[k-1].iq[tmc_pkg::SIDE_W-2:0], 1'b0};
        end
      end

      if (k >= tmc_pkg::ST_CD0 && k <= tmc_pkg::ST_CDN) begin
        cr2 = {p[k-1].crem[tmc_pkg::DIV_W-1:0], p[k-1].cq[tmc_pkg::CIRC_W-1]};
        if (cr2 >= {1'b0, p[k-1].div}) begin
          nx.crem = cr2 - {1'b0, p[k-1].div};
          nx.cq   = {p[k-1].cq[tmc_pkg::CIRC_W-2:0], 1'b1};
        end else begin
          nx.crem = cr2;
          nx.cq   = {p[k-1].cq[tmc_pkg::CIRC_W-2:0], 1'b0};
        end
      end

      if (k == tmc_pkg::NST) begin
        nx.inr_o  = p[k-1].degen ? '0 : (p[k-1].isat ? '1 : p[k-1].iq);
        nx.circ_o = (p[k-1].degen || p[k-1].csat) ? '1 : p[k-1].cq;
        nx.csat_o = p[k-1].degen || p[k-1].csat;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (adv) begin
        v[k] <= v[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        p[k] <= nx;
      end
    end
  end

  assign metrics.valid            = v[tmc_pkg::NST];
  assign metrics.side_ab          = p[tmc_pkg::NST].root[0];
  assign metrics.side_bc          = p[tmc_pkg::NST].root[1];
  assign metrics.side_ac          = p[tmc_pkg::NST].root[2];
  assign metrics.perimeter        = p[tmc_pkg::NST].per;
  assign metrics.area_twice       = p[tmc_pkg::NST].at;
  assign metrics.shape_class      = p[tmc_pkg::NST].cls;
  assign metrics.inradius         = p[tmc_pkg::NST].inr_o;
  assign metrics.circumradius     = p[tmc_pkg::NST].circ_o;
  assign metrics.degenerate       = p[tmc_pkg::NST].degen;
  assign metrics.circum_saturated = p[tmc_pkg::NST].csat_o;

  a_degen_sat: assert property (@(posedge clk) disable iff (rst)
    metrics.valid && metrics.degenerate |->
      metrics.circum_saturated && (&metrics.circumradius) && metrics.inradius == '0)
    else $error("degenerate word without saturated radii");

  a_perim_sum: assert property (@(posedge clk) disable iff (rst)
    metrics.valid |-> metrics.perimeter ==
      tmc_pkg::perim_t'(metrics.side_ab) + tmc_pkg::perim_t'(metrics.side_bc) +
      tmc_pkg::perim_t'(metrics.side_ac))
    else $error("perimeter differs from sum of sides");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(v[tmc_pkg::NST:1]))
    else $error("pipeline moved while stalled");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    adv && v[tmc_pkg::NST-1] |=> metrics.valid)
    else $error("word lost at last stage");

endmodule
